// ----- design/lpud_pkg.sv -----
// Package for the length-prefixed unit deframer.
// Holds the header size, the register reset value and the result item type.
// No dependencies.
package lpud_pkg;

  localparam int unsigned HdrBytes = 4;
  localparam int unsigned FillW = 3;
  localparam int unsigned CntW = 3;
  localparam logic [31:0] MaxLenReset = 32'd10000000;
  localparam logic [FillW-1:0] FillFull = FillW'(HdrBytes);
  localparam logic [FillW-1:0] FillResync = FillW'(HdrBytes - 1);
  localparam logic [CntW-1:0] CntHdr = CntW'(HdrBytes);

  // One result item waiting at the output.
  typedef struct packed {
    logic [7:0] data;
    logic trunc;
    logic fin;
    logic start;
  } res_t;

endpackage

// ----- design/length_prefixed_unit_deframer_unit.sv -----
// Top level of the length-prefixed unit deframer (32-bit big-endian header).
// Depends on lpud_pkg for the header size, register reset value and result type.
//
//  channel  | direction | tdata            | tuser                    | tlast
//  s_*      | in        | [7:0] data_byte  | -                        | end_of_input
//  m_*      | out       | [7:0] out_byte   | [0] start [1] end [2] trunc | last
//  cfg_*    | in        | [31:0] max_length| -                        | -
//
// An input item causing at most one result is taken as the previous result leaves;
// an item that completes a header causes four results and holds the next item until
// the four-entry result buffer, draining one item a cycle while m_tready is high, sends its last entry.
// Input sits in a one-item skid register, so a byte is taken while a result waits.
// Synchronous reset clears stream state, buffers and sets max_length to 10000000.
// cfg_ready is always high; configuration must be written while the block is idle (not enforced here).
module length_prefixed_unit_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [2:0]  m_tuser,   // [0] unit_start, [1] unit_end, [2] truncated
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import lpud_pkg::*;

  logic [31:0] max_length;

  // input skid register
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_eoi;

  // stream state
  logic [31:0]      header_window;
  logic [FillW-1:0] window_fill;
  logic             in_payload;
  logic [31:0]      bytes_remaining;

  // result buffer, entry 0 is at the output
  res_t            res [HdrBytes];
  logic [CntW-1:0] res_cnt;

  logic buf_free;
  logic proc_fire;
  logic pop;

  logic [31:0]      header_window_next;
  logic [FillW-1:0] window_fill_next;
  logic             in_payload_next;
  logic [31:0]      bytes_remaining_next;
  logic [31:0]      win;
  logic [FillW-1:0] fill_inc;
  logic [31:0]      rem_dec;
  logic [CntW-1:0]  n_res;
  res_t             new_res [HdrBytes];

  assign cfg_ready = 1'b1;
  assign pop       = m_tvalid && m_tready;
  assign buf_free  = (res_cnt == '0) || ((res_cnt == CntW'(1)) && m_tready);
  assign proc_fire = in_vld && buf_free;
  assign s_tready  = !in_vld || proc_fire;

  assign m_tvalid = (res_cnt != '0);
  assign m_tdata  = res[0].data;
  assign m_tuser  = {res[0].trunc, res[0].fin, res[0].start};
  assign m_tlast  = (res_cnt == CntW'(1));

  always_comb begin
    header_window_next   = header_window;
    window_fill_next     = window_fill;
    in_payload_next      = in_payload;
    bytes_remaining_next = bytes_remaining;
    n_res                = '0;
    win                  = {header_window[23:0], in_byte};
    fill_inc             = window_fill + FillW'(1);
    rem_dec              = bytes_remaining - {31'd0, (bytes_remaining != '0)};
    for (int i = 0; i < HdrBytes; i++) begin
      new_res[i] = '{data: win[8*(HdrBytes-1-i) +: 8], trunc: 1'b0, fin: 1'b0,
                     start: 1'b0};
    end
    if (in_payload) begin
      n_res = CntW'(1);
      new_res[0].data = in_byte;
      bytes_remaining_next = rem_dec;
      if (rem_dec == '0) begin
        new_res[0].fin  = 1'b1;
        in_payload_next = 1'b0;
      end else begin
        new_res[0].fin   = in_eoi;
        new_res[0].trunc = in_eoi;
      end
    end else begin
      header_window_next = win;
      window_fill_next   = fill_inc;
      if (fill_inc == FillFull) begin
        if ((win == '0) || (win > max_length)) begin
          // drop the oldest byte and slide on
          window_fill_next = FillResync;
        end else begin
          n_res                   = CntHdr;
          new_res[0].start        = 1'b1;
          new_res[HdrBytes-1].fin   = in_eoi;
          new_res[HdrBytes-1].trunc = in_eoi;
          in_payload_next         = 1'b1;
          bytes_remaining_next    = win;
          header_window_next      = '0;
          window_fill_next        = '0;
        end
      end
    end
    if (in_eoi) begin
      header_window_next   = '0;
      window_fill_next     = '0;
      in_payload_next      = 1'b0;
      bytes_remaining_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length      <= MaxLenReset;
      in_vld          <= 1'b0;
      header_window   <= '0;
      window_fill     <= '0;
      in_payload      <= 1'b0;
      bytes_remaining <= '0;
      res_cnt         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_length <= cfg_data;
      end
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (proc_fire) begin
        header_window   <= header_window_next;
        window_fill     <= window_fill_next;
        in_payload      <= in_payload_next;
        bytes_remaining <= bytes_remaining_next;
        res_cnt         <= n_res;
      end else if (pop) begin
        res_cnt <= res_cnt - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
    if (proc_fire) begin
      for (int i = 0; i < HdrBytes; i++) begin
        res[i] <= new_res[i];
      end
    end else if (pop) begin
      // advance the burst one item
      for (int i = 0; i < HdrBytes - 1; i++) begin
        res[i] <= res[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    res_cnt <= CntHdr)
    else $error("result count above header size");

  a_start_burst: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (res_cnt == CntHdr))
    else $error("unit start outside a full header burst");

  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> (bytes_remaining != '0))
    else $error("payload phase with nothing remaining");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !buf_free) |=> (in_vld && $stable(in_byte) && $stable(in_eoi)))
    else $error("pending input lost while result buffer busy");
`endif

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for length_prefixed_unit_deframer_unit.
// Streams byte units with big-endian length headers and checks every output item
// against an in-bench deframer model; depends on lpud_pkg and the block itself.
module tb_top;
  import lpud_pkg::*;

  localparam int ClkHalf = 5;
  localparam int WatchdogLimit = 1000;
  localparam int SettleCycles = 16;
  localparam int PhaseBytes = 56;
  localparam int NumPhases = 5;

  // Expected output item; the last flag marks the final item of one input byte.
  typedef struct packed {
    logic [7:0] data;
    logic start;
    logic fin;
    logic trunc;
    logic last;
  } unit_byte_t;

  class deframer_scoreboard;
    logic [31:0] max_len;
    logic [31:0] hdr_window;
    int unsigned hdr_fill;
    bit in_body;
    logic [31:0] body_left;
    unit_byte_t expected_q[$];
    int errors;

    function new();
      max_len = MaxLenReset;
      errors = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      hdr_window = '0;
      hdr_fill = 0;
      in_body = 0;
      body_left = '0;
    endfunction

    function void set_max_len(logic [31:0] v);
      max_len = v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the deframer by one accepted input byte and queue what it emits.
    function void note_byte(logic [7:0] b, logic eoi);
      unit_byte_t batch[$];
      unit_byte_t e;
      if (in_body) begin
        if (body_left != 0) body_left--;
        e = '{data: b, start: 1'b0, fin: 1'b1, trunc: 1'b0, last: 1'b0};
        if (body_left == 0) begin
          in_body = 0;
        end else begin
          e.fin = eoi;
          e.trunc = eoi;
        end
        batch = {batch, e};
      end else begin
        hdr_window = {hdr_window[23:0], b};
        if (hdr_fill < HdrBytes) hdr_fill++;
        if (hdr_fill >= HdrBytes) begin
          if (hdr_window == 0 || hdr_window > max_len) begin
            // reject: drop the oldest byte and keep sliding
            hdr_fill = HdrBytes - 1;
          end else begin
            for (int i = 0; i < HdrBytes; i++) begin
              e.data = hdr_window[8*(3-i) +: 8];
              e.start = (i == 0);
              e.fin = (i == HdrBytes - 1) && eoi;
              e.trunc = e.fin;
              e.last = 1'b0;
              batch = {batch, e};
            end
            in_body = 1;
            body_left = hdr_window;
            hdr_window = '0;
            hdr_fill = 0;
          end
        end
      end
      if (eoi) clear_stream();
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_q = {expected_q, batch[i]};
    endfunction

    function void check_result(logic [7:0] data, logic [2:0] user, logic last);
      unit_byte_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item: byte %02h tuser %03b tlast %0b",
                 $time, data, user, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (data !== e.data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, e.data, data);
        errors++;
      end
      if (user[0] !== e.start) begin
        $display("%0t: unit_start expected %0b actual %0b", $time, e.start, user[0]);
        errors++;
      end
      if (user[1] !== e.fin) begin
        $display("%0t: unit_end expected %0b actual %0b", $time, e.fin, user[1]);
        errors++;
      end
      if (user[2] !== e.trunc) begin
        $display("%0t: truncated expected %0b actual %0b", $time, e.trunc, user[2]);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [7:0] data_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;         // [7:0] out_byte
  logic [2:0]  m_tuser;         // [0] unit_start, [1] unit_end, [2] truncated
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  deframer_scoreboard sb = new();
  bit idle_en = 1'b1;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  length_prefixed_unit_deframer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #ClkHalf clk = ~clk;

  always @(negedge clk) begin
    m_tready <= !idle_en || ($urandom_range(0, 99) >= 8);
  end

  // Inputs are noted before outputs are checked, so a same-edge pair stays ordered.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_max_len(cfg_data);
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eoi);
    @(negedge clk);
    while (idle_en && $urandom_range(0, 99) < 8) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eoi;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Header for len, then nbody payload bytes; eoi goes on the final byte sent.
  task automatic send_unit(input logic [31:0] len, input int unsigned nbody,
                           input logic eoi);
    for (int i = 0; i < HdrBytes; i++)
      send_byte(len[8*(3-i) +: 8], eoi && nbody == 0 && i == HdrBytes - 1);
    for (int unsigned j = 0; j < nbody; j++)
      send_byte(8'($urandom_range(0, 255)), eoi && j == nbody - 1);
  endtask

  // Hold the input until every expected item is out, then let the skid settle.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [31:0] lim);
    int unsigned first;
    int unsigned r;
    int unsigned cap;
    int unsigned k;
    logic [31:0] len;
    first = bytes_sent;
    cap = (lim > 10) ? 10 : lim;
    while (bytes_sent - first < PhaseBytes) begin
      r = $urandom_range(0, 99);
      if (r < 58) begin
        len = $urandom_range(1, cap);
        send_unit(len, len, $urandom_range(0, 99) < 15);
        if ($urandom_range(0, 19) == 0) drain();
      end else if (r < 70) begin
        // length right at the limit or one past it
        len = $urandom_range(0, 1) ? lim : lim + 32'd1;
        if (len != 0 && len <= lim && len <= 10)
          send_unit(len, len, 1'b0);
        else
          send_unit(len, $urandom_range(0, 3), 1'b1);
      end else if (r < 85) begin
        len = $urandom_range(1, cap);
        send_unit(len, $urandom_range(0, len - 1), 1'b1);
      end else begin
        k = $urandom_range(1, 6);
        for (int unsigned j = 0; j < k; j++)
          send_byte(8'($urandom_range(0, 255)), j == k - 1 && $urandom_range(0, 3) != 0);
      end
    end
  endtask

  initial begin
    logic [31:0] lim;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // one-byte unit
    send_unit(32'd1, 1, 1'b0);
    // zero header slides into a valid two-byte header
    send_byte(8'h00, 1'b0);
    send_unit(32'd2, 2, 1'b0);
    // oversized header, then end of input while searching
    send_unit(32'hFFFF_FFFF, 0, 1'b0);
    send_byte(8'h01, 1'b1);
    // end of input on the header byte itself
    send_unit(32'd3, 0, 1'b1);
    // payload cut short
    send_unit(32'd5, 2, 1'b1);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: lim = 32'd1;
        1: lim = 32'hFFFF_FFFF;
        2: lim = $urandom_range(2, 12);
        3: begin
          lim = $urandom();
          if (lim == 0) lim = 32'd1;
        end
        default: lim = MaxLenReset;
      endcase
      write_max_len(lim);
      idle_en = (p != 2);
      run_phase(lim);
      drain();
    end

    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- length_prefixed_unit_deframer_unit.f -----
design/lpud_pkg.sv
design/length_prefixed_unit_deframer_unit.sv
tb/tb_top.sv
